@@ rtl/dmrc_pkg.sv @@
// Shared definitions for the degree multiset rank counter.
// Field widths, action and status codes, and control structs between modules.
// No dependencies.
`default_nettype none

package dmrc_pkg;

  // Widths of the transfer fields.
  localparam int ACT_W    = 3;
  localparam int DEG_W    = 12;
  localparam int RANK_W   = 24;
  localparam int TOTAL_W  = 24;
  localparam int STATUS_W = 3;

  // Action codes; codes above the last query code are invalid.
  localparam logic [ACT_W-1:0] ACT_DEC       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INC       = 3'd1;
  localparam logic [ACT_W-1:0] ACT_QRY_FIRST = 3'd2;
  localparam logic [ACT_W-1:0] ACT_QRY_LAST  = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DEC_ZERO  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

  // Command to the prefix tree walker.
  typedef struct packed {
    logic start;  // begin a walk this cycle
    logic query;  // prefix sum when set, point update otherwise
    logic inc;    // update adds one when set, subtracts one otherwise
  } tree_cmd_t;

  // Status of the prefix tree walker.
  typedef struct packed {
    logic busy;   // a walk is in progress
    logic done;   // one-cycle pulse after a walk has finished
  } tree_sts_t;

endpackage

`default_nettype wire

@@ rtl/dmrc_req_if.sv @@
// Request channel of the degree multiset rank counter.
// Carries valid, ready, action and degree; depends on dmrc_pkg.
`default_nettype none

interface dmrc_req_if;
  logic                        valid;
  logic                        ready;
  logic [dmrc_pkg::ACT_W-1:0]  action;
  logic [dmrc_pkg::DEG_W-1:0]  degree;

  modport source (output valid, output action, output degree, input ready);
  modport sink   (input valid, input action, input degree, output ready);
endinterface

`default_nettype wire

@@ rtl/dmrc_rsp_if.sv @@
// Result channel of the degree multiset rank counter.
// Carries valid, ready and the result fields; depends on dmrc_pkg.
`default_nettype none

interface dmrc_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [dmrc_pkg::ACT_W-1:0]     query_kind;
  logic [dmrc_pkg::DEG_W-1:0]     degree_echo;
  logic [dmrc_pkg::RANK_W-1:0]    rank;
  logic [dmrc_pkg::TOTAL_W-1:0]   total;
  logic [dmrc_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output query_kind, output degree_echo, output rank,
                  output total, output status, input ready);
  modport sink   (input valid, input query_kind, input degree_echo, input rank,
                  input total, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/dmrc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dmrc_ram #(
  parameter int Width = 24,
  parameter int Depth = 4096,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire              clk_i,
  input  wire              we_i,
  input  wire [AddrW-1:0]  waddr_i,
  input  wire [Width-1:0]  wdata_i,
  input  wire [AddrW-1:0]  raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write first in program order; a read of the same address returns old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/dmrc_tree.sv @@
// Prefix count tree (binary indexed tree) held in one RAM, with its walker.
// Does one read-modify-write or one accumulate per cycle; depends on dmrc_pkg, dmrc_ram.
`default_nettype none

module dmrc_tree #(
  parameter int NumDegrees = 4096,
  parameter int CountBits  = 24,
  localparam int IdxW  = $clog2(NumDegrees),
  localparam int TIdxW = IdxW + 2
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire dmrc_pkg::tree_cmd_t  cmd_i,
  input  wire [TIdxW-1:0]           idx_i,
  input  wire                       clr_en_i,
  input  wire [IdxW-1:0]            clr_addr_i,
  output dmrc_pkg::tree_sts_t       sts_o,
  output logic [CountBits-1:0]      sum_o
);

  localparam logic [TIdxW-1:0] NumIdx = TIdxW'(NumDegrees);

  logic                 run_q, run_d;
  logic                 pend_q;
  logic                 done_q;
  logic                 query_q, inc_q;
  logic [TIdxW-1:0]     idx_q, idx_d;
  logic [IdxW-1:0]      pend_addr_q;
  logic [CountBits-1:0] sum_q, sum_d;
  logic [TIdxW-1:0]     low_bit;
  logic                 issue;
  logic [IdxW-1:0]      raddr;
  logic [CountBits-1:0] rdata;
  logic                 we;
  logic [IdxW-1:0]      waddr;
  logic [CountBits-1:0] wdata;

  // Node index is one-based; the walk stops at zero or past the last node.
  assign low_bit = idx_q & (~idx_q + 1'b1);
  assign issue   = run_q && (idx_q != '0) && (query_q || (idx_q <= NumIdx));
  assign raddr   = IdxW'(idx_q - 1'b1);

  // Write port: clearing sweep, or write-back of the node read last cycle.
  always_comb begin
    we    = 1'b0;
    waddr = pend_addr_q;
    wdata = rdata + (inc_q ? CountBits'(1) : {CountBits{1'b1}});
    if (clr_en_i) begin
      we    = 1'b1;
      waddr = clr_addr_i;
      wdata = '0;
    end else if (pend_q && !query_q) begin
      we = 1'b1;
    end
  end

  dmrc_ram #(
    .Width (CountBits),
    .Depth (NumDegrees)
  ) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Walk sequencing: queries strip the low bit, updates add it.
  always_comb begin
    run_d = run_q;
    idx_d = idx_q;
    sum_d = sum_q;
    if (!run_q && cmd_i.start) begin
      run_d = 1'b1;
      idx_d = idx_i;
      sum_d = '0;
    end else if (run_q) begin
      if (issue) begin
        idx_d = query_q ? (idx_q - low_bit) : (idx_q + low_bit);
      end else begin
        run_d = 1'b0;
      end
      if (pend_q && query_q) begin
        sum_d = sum_q + rdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      pend_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      pend_q <= issue;
      done_q <= run_q && !issue;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    sum_q       <= sum_d;
    pend_addr_q <= raddr;
    if (!run_q && cmd_i.start) begin
      query_q <= cmd_i.query;
      inc_q   <= cmd_i.inc;
    end
  end

  assign sts_o.busy = run_q;
  assign sts_o.done = done_q;
  assign sum_o      = sum_q;

endmodule

`default_nettype wire

@@ rtl/degree_multiset_rank_counter.sv @@
// Top level of the degree multiset rank counter: control sequencer, count RAM,
// total register and result register. Depends on dmrc_pkg, the channel
// interfaces, dmrc_ram and dmrc_tree.
`default_nettype none

// Keeps one count per degree in a RAM and the same counts in a prefix count
// tree in a second RAM, so a rank query walks at most log2(NUM_DEGREES) tree
// nodes. The tree walker does one node per cycle (read, then write-back
// overlapped with the next read). A query of a present degree walks
// popcount(degree) nodes. A successful increase or decrease makes two tree
// update walks of up to log2(NUM_DEGREES) + 1 and log2(NUM_DEGREES) nodes; an
// increase of degree zero has one walk only. A failing item or a query of
// degree zero makes no tree walk. A result may wait in the output register
// while the next item is taken. After reset both RAMs are cleared in a pass
// over every degree during which no request is accepted.
module degree_multiset_rank_counter #(
  parameter int NUM_DEGREES = 4096,
  parameter int COUNT_BITS  = 24
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  dmrc_req_if.sink    req_i,
  dmrc_rsp_if.source  rsp_o
);

  localparam int IdxW   = $clog2(NUM_DEGREES);
  localparam int TIdxW  = IdxW + 2;
  localparam int DegW   = dmrc_pkg::DEG_W;
  localparam int ExtW   = ((DegW > IdxW) ? DegW : IdxW) + 2;
  localparam int RankW  = dmrc_pkg::RANK_W;
  localparam int TotalW = dmrc_pkg::TOTAL_W;
  localparam logic [ExtW-1:0] NumExt  = ExtW'(NUM_DEGREES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_DEGREES - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_OLD   = 3'd2;
  localparam logic [2:0] S_NEW   = 3'd3;
  localparam logic [2:0] S_TINC  = 3'd4;
  localparam logic [2:0] S_TDEC  = 3'd5;
  localparam logic [2:0] S_QRY   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]                      state_q, state_d;
  logic [IdxW-1:0]                 clr_q, clr_d;
  logic [dmrc_pkg::ACT_W-1:0]      act_q, act_d;
  logic [DegW-1:0]                 deg_q, deg_d;
  logic [COUNT_BITS-1:0]           old_cnt_q, old_cnt_d;
  logic [COUNT_BITS-1:0]           rank_q, rank_d;
  logic [dmrc_pkg::STATUS_W-1:0]   status_q, status_d;
  logic [COUNT_BITS-1:0]           total_q, total_d;

  logic                            out_valid_q;
  logic [dmrc_pkg::ACT_W-1:0]      out_act_q;
  logic [DegW-1:0]                 out_deg_q;
  logic [RankW-1:0]                out_rank_q;
  logic [TotalW-1:0]               out_total_q;
  logic [dmrc_pkg::STATUS_W-1:0]   out_status_q;
  logic                            out_load;

  logic                            accept;
  logic [ExtW-1:0]                 deg_ext, new_ext;
  logic                            deg_in_range, new_in_range, is_change, present;

  logic                            cnt_we;
  logic [IdxW-1:0]                 cnt_waddr, cnt_raddr;
  logic [COUNT_BITS-1:0]           cnt_wdata, cnt_rdata;

  dmrc_pkg::tree_cmd_t             tree_cmd;
  dmrc_pkg::tree_sts_t             tree_sts;
  logic [TIdxW-1:0]                tree_idx;
  logic [COUNT_BITS-1:0]           tree_sum;

  // Request transfer happens only in the idle state.
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // Degree arithmetic, wide enough for any parameter value.
  assign deg_ext      = ExtW'(deg_q);
  assign new_ext      = (act_q == dmrc_pkg::ACT_DEC) ? (deg_ext - 1'b1) : (deg_ext + 1'b1);
  assign deg_in_range = deg_ext < NumExt;
  assign new_in_range = new_ext < NumExt;
  assign is_change    = (act_q == dmrc_pkg::ACT_DEC) || (act_q == dmrc_pkg::ACT_INC);
  assign present      = deg_in_range && (cnt_rdata != '0);

  // The old degree is read at acceptance, the new degree in the cycle after.
  assign cnt_raddr = (state_q == S_IDLE) ? IdxW'(req_i.degree) : IdxW'(new_ext);

  dmrc_ram #(
    .Width (COUNT_BITS),
    .Depth (NUM_DEGREES)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  dmrc_tree #(
    .NumDegrees (NUM_DEGREES),
    .CountBits  (COUNT_BITS)
  ) u_tree (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (tree_cmd),
    .idx_i      (tree_idx),
    .clr_en_i   (state_q == S_CLEAR),
    .clr_addr_i (clr_q),
    .sts_o      (tree_sts),
    .sum_o      (tree_sum)
  );

  // Main sequencer: checks, count updates and tree walks.
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    act_d     = act_q;
    deg_d     = deg_q;
    old_cnt_d = old_cnt_q;
    rank_d    = rank_q;
    status_d  = status_q;
    total_d   = total_q;
    cnt_we    = 1'b0;
    cnt_waddr = clr_q;
    cnt_wdata = '0;
    tree_cmd  = '0;
    tree_idx  = '0;
    out_load  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cnt_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          act_d    = req_i.action;
          deg_d    = req_i.degree;
          rank_d   = '0;
          status_d = dmrc_pkg::ST_OK;
          priority if (req_i.action > dmrc_pkg::ACT_QRY_LAST) begin
            status_d = dmrc_pkg::ST_INVALID;
            state_d  = S_EMIT;
          end else if (req_i.degree == '0 && req_i.action == dmrc_pkg::ACT_DEC) begin
            status_d = dmrc_pkg::ST_DEC_ZERO;
            state_d  = S_EMIT;
          end else if (req_i.degree == '0 && req_i.action >= dmrc_pkg::ACT_QRY_FIRST) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_OLD;
          end
        end
      end
      S_OLD: begin
        old_cnt_d = cnt_rdata;
        priority if (deg_q != '0 && !present) begin
          status_d = dmrc_pkg::ST_NOT_FOUND;
          state_d  = S_EMIT;
        end else if (is_change) begin
          state_d = S_NEW;
        end else begin
          // Rank is the prefix sum over degrees below the asked one.
          tree_cmd.start = 1'b1;
          tree_cmd.query = 1'b1;
          tree_idx       = TIdxW'(deg_ext);
          state_d        = S_QRY;
        end
      end
      S_NEW: begin
        if (!new_in_range || (&cnt_rdata) || (deg_q == '0 && (&total_q))) begin
          status_d = dmrc_pkg::ST_OVERFLOW;
          state_d  = S_EMIT;
        end else begin
          cnt_we    = 1'b1;
          cnt_waddr = IdxW'(new_ext);
          cnt_wdata = cnt_rdata + 1'b1;
          if (deg_q == '0) begin
            total_d = total_q + 1'b1;
          end
          tree_cmd.start = 1'b1;
          tree_cmd.inc   = 1'b1;
          tree_idx       = TIdxW'(new_ext + 1'b1);
          state_d        = S_TINC;
        end
      end
      S_TINC: begin
        if (tree_sts.done) begin
          if (deg_q != '0) begin
            // Remove the entry of the old degree.
            cnt_we         = 1'b1;
            cnt_waddr      = IdxW'(deg_ext);
            cnt_wdata      = old_cnt_q - 1'b1;
            tree_cmd.start = 1'b1;
            tree_idx       = TIdxW'(deg_ext + 1'b1);
            state_d        = S_TDEC;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_TDEC: begin
        if (tree_sts.done) begin
          state_d = S_IDLE;
        end
      end
      S_QRY: begin
        if (tree_sts.done) begin
          rank_d  = tree_sum;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      total_q <= total_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    deg_q     <= deg_d;
    old_cnt_q <= old_cnt_d;
    rank_q    <= rank_d;
    status_q  <= status_d;
    if (out_load) begin
      out_act_q    <= act_q;
      out_deg_q    <= deg_q;
      out_rank_q   <= RankW'(rank_q);
      out_total_q  <= TotalW'(total_q);
      out_status_q <= status_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.query_kind  = out_act_q;
  assign rsp_o.degree_echo = out_deg_q;
  assign rsp_o.rank        = out_rank_q;
  assign rsp_o.total       = out_total_q;
  assign rsp_o.status      = out_status_q;

  // A walk is only started while the walker is free.
  a_tree_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tree_cmd.start |-> !tree_sts.busy)
    else $error("tree walk started while busy");

  // A new result never overwrites one that has not been transferred.
  a_no_result_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || rsp_o.ready))
    else $error("result register overwritten");

  // The total only ever grows by one.
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(total_q) |-> (total_q == $past(total_q) + 1'b1))
    else $error("total changed by other than one");

  // Failed items report rank zero.
  a_err_rank_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != dmrc_pkg::ST_OK) |-> (rsp_o.rank == '0))
    else $error("nonzero rank on a failed item");

  // Walk completion is only seen while the sequencer waits for it.
  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tree_sts.done |-> (state_q == S_TINC || state_q == S_TDEC || state_q == S_QRY))
    else $error("unexpected tree walk completion");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for degree_multiset_rank_counter: directed rows, a short
// degree ladder, then mixed random traffic with random idles.
// Depends on dmrc_pkg, dmrc_req_if, dmrc_rsp_if and the RTL top level.

module tb;

  localparam int NUM_DEG     = 4096;
  localparam int RAND_ITEMS  = 1570;
  localparam int LADDER_TOP  = 256;
  localparam int MAX_REPORTS = 10;
  localparam int TAIL_CYCLES = 100;

  // Field widths taken from the package.
  localparam int ActW    = dmrc_pkg::ACT_W;
  localparam int DegW    = dmrc_pkg::DEG_W;
  localparam int RankW   = dmrc_pkg::RANK_W;
  localparam int TotalW  = dmrc_pkg::TOTAL_W;
  localparam int StatusW = dmrc_pkg::STATUS_W;

  // Action codes that the package does not name individually.
  localparam logic [ActW-1:0] ACT_QRY_2ND = dmrc_pkg::ACT_QRY_FIRST + 3'd1;
  localparam logic [ActW-1:0] ACT_QRY_3RD = dmrc_pkg::ACT_QRY_FIRST + 3'd2;
  localparam logic [ActW-1:0] ACT_BAD_LO  = dmrc_pkg::ACT_QRY_LAST + 3'd1;
  localparam logic [ActW-1:0] ACT_BAD_HI  = '1;

  localparam logic [RankW-1:0] COUNT_MAX = '1;
  localparam logic [DegW-1:0]  DEG_TOP   = '1;

  typedef struct packed {
    logic [ActW-1:0]    kind;
    logic [DegW-1:0]    deg;
    logic [RankW-1:0]   rank;
    logic [TotalW-1:0]  total;
    logic [StatusW-1:0] status;
  } rank_result_t;

  // One directed row; the expected fields are used only when fixed is set.
  typedef struct packed {
    logic [ActW-1:0]    act;
    logic [DegW-1:0]    deg;
    logic               fixed;
    logic [RankW-1:0]   rank;
    logic [TotalW-1:0]  total;
    logic [StatusW-1:0] status;
  } stim_row_t;

  localparam int DIR_ROWS = 21;

  stim_row_t dir_rows [0:DIR_ROWS-1] = '{
    {dmrc_pkg::ACT_QRY_FIRST, 12'd0,    1'b1, 24'd0, 24'd0, dmrc_pkg::ST_OK},
    {dmrc_pkg::ACT_QRY_LAST,  12'd4095, 1'b1, 24'd0, 24'd0, dmrc_pkg::ST_NOT_FOUND},
    {dmrc_pkg::ACT_DEC,       12'd0,    1'b1, 24'd0, 24'd0, dmrc_pkg::ST_DEC_ZERO},
    {dmrc_pkg::ACT_DEC,       12'd4095, 1'b1, 24'd0, 24'd0, dmrc_pkg::ST_NOT_FOUND},
    {dmrc_pkg::ACT_INC,       12'd4095, 1'b1, 24'd0, 24'd0, dmrc_pkg::ST_NOT_FOUND},
    {ACT_BAD_LO,              12'hAAA,  1'b1, 24'd0, 24'd0, dmrc_pkg::ST_INVALID},
    {ACT_BAD_HI,              12'h555,  1'b1, 24'd0, 24'd0, dmrc_pkg::ST_INVALID},
    {dmrc_pkg::ACT_INC,       12'd0,    1'b0, 24'd0, 24'd0, dmrc_pkg::ST_OK},
    {dmrc_pkg::ACT_INC,       12'd0,    1'b0, 24'd0, 24'd0, dmrc_pkg::ST_OK},
    {ACT_QRY_2ND,             12'd1,    1'b0, 24'd0, 24'd0, dmrc_pkg::ST_OK},
    {dmrc_pkg::ACT_INC,       12'd1,    1'b0, 24'd0, 24'd0, dmrc_pkg::ST_OK},
    {dmrc_pkg::ACT_DEC,       12'd1,    1'b0, 24'd0, 24'd0, dmrc_pkg::ST_OK},
    {ACT_QRY_3RD,             12'd1,    1'b0, 24'd0, 24'd0, dmrc_pkg::ST_OK},
    {dmrc_pkg::ACT_QRY_LAST,  12'd2,    1'b0, 24'd0, 24'd0, dmrc_pkg::ST_OK},
    {dmrc_pkg::ACT_DEC,       12'd2,    1'b0, 24'd0, 24'd0, dmrc_pkg::ST_OK},
    {dmrc_pkg::ACT_INC,       12'd3,    1'b1, 24'd0, 24'd2, dmrc_pkg::ST_NOT_FOUND},
    {dmrc_pkg::ACT_QRY_FIRST, 12'd0,    1'b1, 24'd0, 24'd2, dmrc_pkg::ST_OK},
    {ACT_BAD_HI,              12'hFFF,  1'b1, 24'd0, 24'd2, dmrc_pkg::ST_INVALID},
    {dmrc_pkg::ACT_QRY_FIRST, 12'hFFF,  1'b1, 24'd0, 24'd2, dmrc_pkg::ST_NOT_FOUND},
    {dmrc_pkg::ACT_DEC,       12'd0,    1'b1, 24'd0, 24'd2, dmrc_pkg::ST_DEC_ZERO},
    {ACT_QRY_2ND,             12'd1,    1'b0, 24'd0, 24'd0, dmrc_pkg::ST_OK}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Bench-side drivers of the channel inputs.
  logic            req_valid_q = 1'b0;
  logic [ActW-1:0] req_act_q   = '0;
  logic [DegW-1:0] req_deg_q   = '0;
  logic            rsp_ready_q = 1'b0;

  // Shadow state of the multiset.
  logic [RankW-1:0]  deg_count [0:NUM_DEG-1] = '{default: '0};
  logic [TotalW-1:0] entry_count = '0;

  rank_result_t pending_results [$];
  int           fail_count = 0;
  int           rx_stall   = 0;
  bit           tx_calm    = 1'b0;
  bit           rx_calm    = 1'b0;

  dmrc_req_if req ();
  dmrc_rsp_if rsp ();

  assign req.valid  = req_valid_q;
  assign req.action = req_act_q;
  assign req.degree = req_deg_q;
  assign rsp.ready  = rsp_ready_q;

  degree_multiset_rank_counter #(
    .NUM_DEGREES(NUM_DEG),
    .COUNT_BITS (RankW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one item to the shadow state; returns 1 when the item yields a result.
  function automatic bit apply_degree_item(input logic [ActW-1:0] act,
                                           input logic [DegW-1:0] deg,
                                           output rank_result_t res);
    logic [DegW:0]   next_deg;
    longint unsigned sum;
    res        = '0;
    res.kind   = act;
    res.deg    = deg;
    res.total  = entry_count;
    res.status = dmrc_pkg::ST_OK;
    if (act == dmrc_pkg::ACT_DEC || act == dmrc_pkg::ACT_INC) begin
      if (act == dmrc_pkg::ACT_DEC && deg == '0) begin
        res.status = dmrc_pkg::ST_DEC_ZERO;
        return 1'b1;
      end
      next_deg = (act == dmrc_pkg::ACT_DEC) ? {1'b0, deg} - 1'b1 : {1'b0, deg} + 1'b1;
      if (deg != '0 && deg_count[deg] == '0) begin
        res.status = dmrc_pkg::ST_NOT_FOUND;
        return 1'b1;
      end
      if (next_deg >= NUM_DEG || deg_count[next_deg[DegW-1:0]] == COUNT_MAX ||
          (deg == '0 && entry_count == COUNT_MAX)) begin
        res.status = dmrc_pkg::ST_OVERFLOW;
        return 1'b1;
      end
      // A nonzero degree moves; a zero degree brings in a new entry.
      if (deg != '0) deg_count[deg] = deg_count[deg] - 1'b1;
      else entry_count = entry_count + 1'b1;
      deg_count[next_deg[DegW-1:0]] = deg_count[next_deg[DegW-1:0]] + 1'b1;
      return 1'b0;
    end
    if (act >= dmrc_pkg::ACT_QRY_FIRST && act <= dmrc_pkg::ACT_QRY_LAST) begin
      sum = 0;
      if (deg != '0) begin
        if (deg_count[deg] == '0) begin
          res.status = dmrc_pkg::ST_NOT_FOUND;
          return 1'b1;
        end
        for (int i = 0; i < deg; i++) sum += deg_count[i];
      end
      res.rank = sum[RankW-1:0];
      return 1'b1;
    end
    res.status = dmrc_pkg::ST_INVALID;
    return 1'b1;
  endfunction

  // First nonzero degree at or after a random start, wrapping; 0 if none.
  function automatic logic [DegW-1:0] find_present_degree();
    int start;
    int d;
    start = $urandom_range(1, NUM_DEG - 1);
    for (int k = 0; k < NUM_DEG - 1; k++) begin
      d = 1 + (start - 1 + k) % (NUM_DEG - 1);
      if (deg_count[d] != '0) return d[DegW-1:0];
    end
    return '0;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_idle(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Present one item and wait for its transfer, then record what it should yield.
  task automatic send_item(input logic [ActW-1:0] act, input logic [DegW-1:0] deg,
                           input bit fixed, input rank_result_t want);
    int           idle;
    rank_result_t res;
    bit           has_res;
    idle = pick_idle(tx_calm);
    if (idle > 0) begin
      req_valid_q <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    req_valid_q <= 1'b1;
    req_act_q   <= act;
    req_deg_q   <= deg;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    has_res = apply_degree_item(act, deg, res);
    if (fixed) begin
      want.kind = act;
      want.deg  = deg;
      pending_results = {pending_results, want};
    end else if (has_res) begin
      pending_results = {pending_results, res};
    end
  endtask

  // Hold off the sender until every outstanding result has been seen.
  task automatic wait_results_drained();
    req_valid_q <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_result(input rank_result_t got);
    rank_result_t want;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("unexpected result: kind %0d degree %0d rank %0d total %0d status %0d",
                 got.kind, got.deg, got.rank, got.total, got.status);
      return;
    end
    want = pending_results.pop_front();
    if (got.kind != want.kind || got.deg != want.deg || got.rank != want.rank ||
        got.total != want.total || got.status != want.status) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("mismatch: expected kind %0d degree %0d rank %0d total %0d status %0d, %s",
                 want.kind, want.deg, want.rank, want.total, want.status,
                 $sformatf("got kind %0d degree %0d rank %0d total %0d status %0d",
                           got.kind, got.deg, got.rank, got.total, got.status));
    end
  endtask

  // Switch each side between calm stretches and stretches with idles.
  always begin
    repeat ($urandom_range(100, 400)) @(posedge clk_i);
    tx_calm <= ($urandom_range(0, 3) == 0);
    rx_calm <= ($urandom_range(0, 3) == 0);
  end

  // Result side: check every transfer, then choose the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid === 1'b1 && rsp_ready_q)
      check_result({rsp.query_kind, rsp.degree_echo, rsp.rank, rsp.total, rsp.status});
    if (rx_stall > 0) begin
      rsp_ready_q <= 1'b0;
      rx_stall    <= rx_stall - 1;
    end else if (!rx_calm && $urandom_range(0, 9) == 0) begin
      rsp_ready_q <= 1'b0;
      rx_stall    <= ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40)
                                                 : $urandom_range(0, 2);
    end else begin
      rsp_ready_q <= 1'b1;
    end
  end

  // Stimulus: directed rows, the degree ladder, then random items.
  initial begin
    rank_result_t    want;
    logic [ActW-1:0] act;
    logic [DegW-1:0] deg;
    int              pick;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      want        = '0;
      want.rank   = dir_rows[i].rank;
      want.total  = dir_rows[i].total;
      want.status = dir_rows[i].status;
      send_item(dir_rows[i].act, dir_rows[i].deg, dir_rows[i].fixed, want);
    end

    // Walk one new entry from degree 1 up the ladder, then probe the top degree.
    send_item(dmrc_pkg::ACT_INC, '0, 1'b0, '0);
    for (int d = 1; d < LADDER_TOP; d++) begin
      send_item(dmrc_pkg::ACT_INC, d[DegW-1:0], 1'b0, '0);
      if (d % 64 == 0) send_item(ACT_QRY_2ND, d[DegW-1:0] + 1'b1, 1'b0, '0);
    end
    send_item(dmrc_pkg::ACT_QRY_LAST, DEG_TOP, 1'b0, '0);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 2) wait_results_drained();
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        act = dmrc_pkg::ACT_INC;
        deg = '0;
      end else if (pick < 50) begin
        deg = find_present_degree();
        act = (deg != '0 && $urandom_range(0, 1)) ? dmrc_pkg::ACT_DEC : dmrc_pkg::ACT_INC;
      end else if (pick < 75) begin
        deg = find_present_degree();
        act = ActW'($urandom_range(dmrc_pkg::ACT_QRY_FIRST, dmrc_pkg::ACT_QRY_LAST));
      end else if (pick < 80) begin
        deg = '0;
        act = $urandom_range(0, 1) ? dmrc_pkg::ACT_DEC : dmrc_pkg::ACT_QRY_FIRST;
      end else begin
        act = ActW'($urandom_range(0, 7));
        deg = DegW'($urandom_range(0, NUM_DEG - 1));
      end
      send_item(act, deg, 1'b0, '0);
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit, well beyond the slowest correct run.
  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
